// File: src/mfi_pkg.sv
`default_nettype none

package mfi_pkg;

  localparam int unsigned SAMPLE_WIDTH = 16;
  localparam int unsigned STEP_WIDTH   = 8;
  localparam int unsigned NUM_REGS     = 8;
  localparam int unsigned REG_IDX_W    = $clog2(NUM_REGS);
  localparam int unsigned ADDR_WIDTH   = REG_IDX_W + 2;
  localparam int unsigned DATA_WIDTH   = 32;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_UNDER_VOLTAGE  = 3'd0,
    REG_OVER_VOLTAGE   = 3'd1,
    REG_OVER_CURRENT   = 3'd2,
    REG_VOLT_RISE_STEP = 3'd3,
    REG_VOLT_FALL_STEP = 3'd4,
    REG_CURR_RISE_STEP = 3'd5,
    REG_CURR_FALL_STEP = 3'd6,
    REG_AUTO_RESET_EN  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0]        bus_voltage;
    logic signed [SAMPLE_WIDTH-1:0] current_alpha;
    logic signed [SAMPLE_WIDTH-1:0] current_beta;
    logic                           driver_fault;
    logic                           temp_warning;
    logic                           drive_enabled;
    logic                           ignore_faults;
    logic                           starting_up;
    logic                           reset_pending;
  } mfi_in_t;

  typedef struct packed {
    logic shutdown_request;
    logic error_seen;
    logic voltage_fault;
    logic current_fault;
    logic temp_fault;
    logic any_error;
    logic reset_request;
  } mfi_out_t;

endpackage

`default_nettype wire

// File: src/motor_fault_integrator_core.sv
`default_nettype none

// channel | valid       | stall       | beat
// --------+-------------+-------------+----------------------
// input   | in_valid_i  | in_stall_o  | in_beat_i  (mfi_in_t)
// output  | out_valid_o | out_stall_i | out_beat_o (mfi_out_t)
// config  | psel/penable/pwrite, pready tied high, 4-byte register stride
//
// input beat to result beat passes the input register, then the result register
// one beat per cycle sustained while out_stall_i is low; both buckets update in the single compare/add stage
// reset clears counters, latches, valid flags and loads register defaults
// a stalled result holds the input register; input stalls only when both are full

module motor_fault_integrator_core #(
  parameter int unsigned TRIP_LEVEL = 1024
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire mfi_pkg::mfi_in_t                    in_beat_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output mfi_pkg::mfi_out_t                        out_beat_o,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [mfi_pkg::ADDR_WIDTH-1:0]      paddr,
  input  wire logic [mfi_pkg::DATA_WIDTH-1:0]      pwdata,
  output logic      [mfi_pkg::DATA_WIDTH-1:0]      prdata,
  output logic                                     pready
);

  import mfi_pkg::*;

  localparam int unsigned CNT_WIDTH = $clog2(TRIP_LEVEL + 255);
  localparam logic [CNT_WIDTH-1:0] PresetCount = CNT_WIDTH'(TRIP_LEVEL - 1);
  localparam logic [CNT_WIDTH-1:0] PeakCount   = CNT_WIDTH'(TRIP_LEVEL + 254);

  // configuration registers
  logic [SAMPLE_WIDTH-1:0]        uv_lim_q;
  logic [SAMPLE_WIDTH-1:0]        ov_lim_q;
  logic signed [SAMPLE_WIDTH-1:0] oc_lim_q;
  logic [STEP_WIDTH-1:0]          v_rise_q;
  logic [STEP_WIDTH-1:0]          v_fall_q;
  logic [STEP_WIDTH-1:0]          c_rise_q;
  logic [STEP_WIDTH-1:0]          c_fall_q;
  logic                           auto_rst_q;

  reg_idx_e reg_idx;
  logic     cfg_wr;

  assign reg_idx = reg_idx_e'(paddr[ADDR_WIDTH-1:2]);
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uv_lim_q   <= '0;
      ov_lim_q   <= '1;
      oc_lim_q   <= {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      v_rise_q   <= STEP_WIDTH'(1);
      v_fall_q   <= STEP_WIDTH'(1);
      c_rise_q   <= STEP_WIDTH'(1);
      c_fall_q   <= STEP_WIDTH'(1);
      auto_rst_q <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_UNDER_VOLTAGE:  uv_lim_q   <= pwdata[SAMPLE_WIDTH-1:0];
        REG_OVER_VOLTAGE:   ov_lim_q   <= pwdata[SAMPLE_WIDTH-1:0];
        REG_OVER_CURRENT:   oc_lim_q   <= pwdata[SAMPLE_WIDTH-1:0];
        REG_VOLT_RISE_STEP: v_rise_q   <= pwdata[STEP_WIDTH-1:0];
        REG_VOLT_FALL_STEP: v_fall_q   <= pwdata[STEP_WIDTH-1:0];
        REG_CURR_RISE_STEP: c_rise_q   <= pwdata[STEP_WIDTH-1:0];
        REG_CURR_FALL_STEP: c_fall_q   <= pwdata[STEP_WIDTH-1:0];
        REG_AUTO_RESET_EN:  auto_rst_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_UNDER_VOLTAGE:  prdata = DATA_WIDTH'(uv_lim_q);
      REG_OVER_VOLTAGE:   prdata = DATA_WIDTH'(ov_lim_q);
      REG_OVER_CURRENT:   prdata = DATA_WIDTH'($unsigned(oc_lim_q));
      REG_VOLT_RISE_STEP: prdata = DATA_WIDTH'(v_rise_q);
      REG_VOLT_FALL_STEP: prdata = DATA_WIDTH'(v_fall_q);
      REG_CURR_RISE_STEP: prdata = DATA_WIDTH'(c_rise_q);
      REG_CURR_FALL_STEP: prdata = DATA_WIDTH'(c_fall_q);
      REG_AUTO_RESET_EN:  prdata = DATA_WIDTH'(auto_rst_q);
      default:            prdata = '0;
    endcase
  end

  // pipeline control
  logic    in_vld_q;
  mfi_in_t in_q;
  logic    out_vld_q;
  mfi_out_t out_q;
  logic    advance;

  assign advance     = ~out_vld_q | ~out_stall_i;
  assign in_stall_o  = in_vld_q & ~advance;
  assign out_valid_o = out_vld_q;
  assign out_beat_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_beat_i;
    end
  end

  // fault state
  logic [CNT_WIDTH-1:0] v_cnt_q, v_cnt_d;
  logic [CNT_WIDTH-1:0] c_cnt_q, c_cnt_d;
  logic v_latch_q, v_latch_d;
  logic c_latch_q, c_latch_d;
  logic t_latch_q, t_latch_d;
  logic sticky_q, sticky_d;
  mfi_out_t res_d;

  logic                 drv_trip;
  logic                 checks;
  logic                 v_bad;
  logic                 c_bad;
  logic [CNT_WIDTH-1:0] v_cnt_pre;
  logic [CNT_WIDTH-1:0] c_cnt_pre;
  logic [CNT_WIDTH-1:0] v_cnt_new;
  logic [CNT_WIDTH-1:0] c_cnt_new;
  logic v_trip, v_empty, c_trip, c_empty;
  logic shutdown;
  logic any_err;

  assign drv_trip  = in_q.driver_fault & in_q.drive_enabled;
  assign checks    = ~in_q.ignore_faults & ~in_q.starting_up;
  assign v_cnt_pre = drv_trip ? PresetCount : v_cnt_q;
  assign c_cnt_pre = drv_trip ? PresetCount : c_cnt_q;
  assign v_bad     = (in_q.bus_voltage < uv_lim_q) | (in_q.bus_voltage > ov_lim_q);
  assign c_bad     = (in_q.current_alpha > oc_lim_q) | (in_q.current_beta > oc_lim_q);

  mfi_bucket #(
    .TRIP_LEVEL(TRIP_LEVEL),
    .CNT_WIDTH (CNT_WIDTH)
  ) u_v_bucket (
    .count_i(v_cnt_pre),
    .bad_i  (v_bad),
    .rise_i (v_rise_q),
    .fall_i (v_fall_q),
    .count_o(v_cnt_new),
    .trip_o (v_trip),
    .empty_o(v_empty)
  );

  mfi_bucket #(
    .TRIP_LEVEL(TRIP_LEVEL),
    .CNT_WIDTH (CNT_WIDTH)
  ) u_c_bucket (
    .count_i(c_cnt_pre),
    .bad_i  (c_bad),
    .rise_i (c_rise_q),
    .fall_i (c_fall_q),
    .count_o(c_cnt_new),
    .trip_o (c_trip),
    .empty_o(c_empty)
  );

  always_comb begin
    v_cnt_d   = v_cnt_pre;
    c_cnt_d   = c_cnt_pre;
    v_latch_d = v_latch_q;
    c_latch_d = c_latch_q;
    t_latch_d = t_latch_q | (in_q.driver_fault & in_q.temp_warning);
    shutdown  = drv_trip;
    if (checks) begin
      v_cnt_d = v_cnt_new;
      c_cnt_d = c_cnt_new;
      if (v_trip) begin
        v_latch_d = 1'b1;
      end else if (v_empty) begin
        v_latch_d = 1'b0;
      end
      if (c_trip) begin
        c_latch_d = 1'b1;
      end else if (c_empty) begin
        c_latch_d = 1'b0;
      end
      shutdown = drv_trip | v_trip | c_trip;
    end
    sticky_d = sticky_q | shutdown;
    any_err  = in_q.driver_fault | v_latch_d | t_latch_d | in_q.temp_warning | c_latch_d;

    res_d.shutdown_request = shutdown;
    res_d.error_seen       = sticky_d;
    res_d.voltage_fault    = v_latch_d;
    res_d.current_fault    = c_latch_d;
    res_d.temp_fault       = t_latch_d;
    res_d.any_error        = any_err;
    res_d.reset_request    = checks & (~in_q.drive_enabled | shutdown) &
                             ~in_q.reset_pending & ~any_err & auto_rst_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_cnt_q   <= '0;
      c_cnt_q   <= '0;
      v_latch_q <= 1'b0;
      c_latch_q <= 1'b0;
      t_latch_q <= 1'b0;
      sticky_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
      if (in_vld_q) begin
        v_cnt_q   <= v_cnt_d;
        c_cnt_q   <= c_cnt_d;
        v_latch_q <= v_latch_d;
        c_latch_q <= c_latch_d;
        t_latch_q <= t_latch_d;
        sticky_q  <= sticky_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_vld_q) begin
      out_q <= res_d;
    end
  end

  a_latch_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_latch_q | c_latch_q) |-> sticky_q)
    else $error("fault latch set without sticky error");

  a_cnt_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_cnt_q <= PeakCount) && (c_cnt_q <= PeakCount))
    else $error("bucket counter above peak");

  a_rst_req_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.reset_request) |-> !out_q.any_error)
    else $error("reset request with error present");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && out_vld_q && out_stall_i))
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

// File: src/mfi_bucket.sv
`default_nettype none

module mfi_bucket #(
  parameter int unsigned TRIP_LEVEL = 1024,
  parameter int unsigned CNT_WIDTH  = 11
) (
  input  wire logic [CNT_WIDTH-1:0] count_i,
  input  wire logic                 bad_i,
  input  wire logic [7:0]           rise_i,
  input  wire logic [7:0]           fall_i,
  output logic      [CNT_WIDTH-1:0] count_o,
  output logic                      trip_o,
  output logic                      empty_o
);

  localparam logic [CNT_WIDTH-1:0] Trip = CNT_WIDTH'(TRIP_LEVEL);

  logic [CNT_WIDTH-1:0] rise_ext;
  logic [CNT_WIDTH-1:0] fall_ext;

  assign rise_ext = CNT_WIDTH'(rise_i);
  assign fall_ext = CNT_WIDTH'(fall_i);

  always_comb begin
    if (bad_i) begin
      count_o = (count_i < Trip) ? count_i + rise_ext : count_i;
    end else begin
      count_o = (count_i > fall_ext) ? count_i - fall_ext : '0;
    end
  end

  assign trip_o  = (count_o >= Trip);
  assign empty_o = (count_o == '0);

endmodule

`default_nettype wire
